/* rtl/ttcp_pkg.sv */
// Shared types, constants and defaults for the time tag coincidence packer.
package ttcp_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int TS_W        = 63;
    localparam int CH_W        = 6;
    localparam int MASK_W      = 8;
    localparam int TBL_W       = 48;
    localparam int CIU_W       = 4;
    localparam int TIME_W_MAX  = 49;
    localparam int IN_W        = ((TS_W + CH_W + 7) / 8) * 8;
    localparam int CFG_ADDR_W  = 1;

    // Parameter defaults for the top level.
    localparam int NUM_SLOTS_DEF       = 8;
    localparam int CHANNEL_ID_BITS_DEF = 6;
    localparam int TIME_BITS_DEF       = 49;

    // Division by 125 as a multiplication by floor(2^70 / 125) and a
    // one-step correction on the remainder.
    localparam logic [15:0] TIME_DIV  = 16'd125;
    localparam logic [63:0] RECIP_M   = 64'd9444732965739290427;
    localparam logic [31:0] RECIP_LO  = RECIP_M[31:0];
    localparam logic [31:0] RECIP_HI  = RECIP_M[63:32];
    localparam int          QUO_W     = 56;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_TABLE   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNELS_IN_USE = 1'b1;

    // Configuration reset values.
    localparam logic [TBL_W-1:0] CHANNEL_TABLE_RST   = 48'd31204079050816;
    localparam logic [CIU_W-1:0] CHANNELS_IN_USE_RST = 4'd8;

    // Marker codes of an output word.
    localparam logic MARKER_NONE     = 1'b0;
    localparam logic MARKER_OVERFLOW = 1'b1;

    // Queue between the front and the back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // One classified tag as it travels from the front to the back.
    typedef struct packed {
        logic [TIME_W_MAX-1:0] tag_time;
        logic [MASK_W-1:0]     mask;
        logic                  ovf;
    } ttcp_item_t;

    // Which word of an overflow tag the back is about to send.
    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } ttcp_phase_t;

endpackage

/* rtl/ttcp_front.sv */
// Front end: slot matching and a pipelined divide-by-125 of the timestamp.
module ttcp_front
    import ttcp_pkg::*;
#(
    parameter int NUM_SLOTS       = NUM_SLOTS_DEF,
    parameter int CHANNEL_ID_BITS = CHANNEL_ID_BITS_DEF,
    parameter int TIME_BITS       = TIME_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TS_W-1:0]   in_ts,
    input  logic [CH_W-1:0]   in_ch,
    input  logic              in_ovf,
    input  logic [TBL_W-1:0]  channel_table,
    input  logic [CIU_W-1:0]  channels_in_use,
    output logic              out_valid,
    input  logic              out_ready,
    output ttcp_item_t        out_item
);

    localparam int EXT_W = TBL_W + NUM_SLOTS * CHANNEL_ID_BITS;
    localparam int CMP_W = (CHANNEL_ID_BITS > CH_W) ? CHANNEL_ID_BITS : CH_W;

    logic [EXT_W-1:0]  tbl_ext;
    logic [MASK_W-1:0] match;
    logic              adv;

    logic [4:0]        v_reg;

    logic [TS_W-1:0]   ts1_reg;
    logic [MASK_W-1:0] mm1_reg, mm2_reg, mm3_reg, mm4_reg, mm5_reg;
    logic              ovf1_reg, ovf2_reg, ovf3_reg, ovf4_reg, ovf5_reg;

    logic [63:0]       pp0_reg, pp1_reg;
    logic [62:0]       pp2_reg, pp3_reg, pp3b_reg;
    logic [15:0]       ts2_reg, ts3_reg, ts4_reg;

    logic [64:0]       mid_reg;
    logic [94:0]       prod_hi;
    logic [QUO_W-1:0]  q4_reg;

    logic [15:0]       rem;
    logic [TIME_BITS-1:0] qt5_reg;
    logic              fix5_reg;
    logic [TIME_BITS-1:0] q_final;

    // Slot n compares its id, zero beyond the table, against the tag's channel.
    assign tbl_ext = {{(NUM_SLOTS * CHANNEL_ID_BITS){1'b0}}, channel_table};

    always_comb begin
        match = '0;
        for (int n = 0; n < NUM_SLOTS; n++) begin
            if ((CMP_W'(tbl_ext[n * CHANNEL_ID_BITS +: CHANNEL_ID_BITS]) == CMP_W'(in_ch))
                    && (channels_in_use > CIU_W'(n))) begin
                match[n] = 1'b1;
            end
        end
    end

    // The whole pipeline moves together unless its last stage is blocked.
    assign adv      = !v_reg[4] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    // Upper part of the reciprocal product; the low 32 bits of pp0 cannot carry.
    assign prod_hi = {pp3b_reg, 32'b0} + 95'(mid_reg);

    assign rem     = ts4_reg - q4_reg[15:0] * TIME_DIV;
    assign q_final = qt5_reg + TIME_BITS'(fix5_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            ts1_reg  <= in_ts;
            mm1_reg  <= match;
            ovf1_reg <= in_ovf;

            pp0_reg  <= {32'b0, ts1_reg[31:0]} * {32'b0, RECIP_LO};
            pp1_reg  <= {32'b0, ts1_reg[31:0]} * {32'b0, RECIP_HI};
            pp2_reg  <= {32'b0, ts1_reg[62:32]} * {31'b0, RECIP_LO};
            pp3_reg  <= {32'b0, ts1_reg[62:32]} * {31'b0, RECIP_HI};
            ts2_reg  <= ts1_reg[15:0];
            mm2_reg  <= mm1_reg;
            ovf2_reg <= ovf1_reg;

            mid_reg  <= 65'(pp1_reg) + 65'(pp2_reg) + 65'(pp0_reg[63:32]);
            pp3b_reg <= pp3_reg;
            ts3_reg  <= ts2_reg;
            mm3_reg  <= mm2_reg;
            ovf3_reg <= ovf2_reg;

            q4_reg   <= prod_hi[93:38];
            ts4_reg  <= ts3_reg;
            mm4_reg  <= mm3_reg;
            ovf4_reg <= ovf3_reg;

            qt5_reg  <= q4_reg[TIME_BITS-1:0];
            fix5_reg <= (rem >= TIME_DIV);
            mm5_reg  <= mm4_reg;
            ovf5_reg <= ovf4_reg;
        end
    end

    assign out_valid         = v_reg[4];
    assign out_item.tag_time = TIME_W_MAX'(q_final);
    assign out_item.mask     = mm5_reg;
    assign out_item.ovf      = ovf5_reg;

endmodule

/* rtl/ttcp_fifo.sv */
// Short queue of classified tags between the front and the back.
module ttcp_fifo
    import ttcp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_valid,
    output logic       wr_ready,
    input  ttcp_item_t wr_item,
    output logic       rd_valid,
    input  logic       rd_pop,
    output ttcp_item_t rd_item
);

    ttcp_item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    do_wr, do_rd;

    assign wr_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_comb begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item = mem_reg[rd_ptr_reg];

endmodule

/* rtl/ttcp_back.sv */
// Back end: pending coincidence word, flush and overflow marker sequencing.
module ttcp_back
    import ttcp_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int OUT_W     = ((TIME_BITS + 1 + MASK_W + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  ttcp_item_t       head_item,
    output logic             head_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    ttcp_phase_t           phase_reg, phase_next;
    logic [TIME_W_MAX-1:0] pend_time_reg, pend_time_next;
    logic [MASK_W-1:0]     pend_mask_reg, pend_mask_next;

    logic                  out_valid_reg;
    logic [TIME_BITS-1:0]  out_time_reg;
    logic                  out_marker_reg;
    logic [MASK_W-1:0]     out_mask_reg;
    logic                  out_last_reg;

    logic pend_any, hit, time_diff, flush_now, emit_any, two_words;
    logic out_free, sel_marker, is_last, load_out;

    assign pend_any   = (pend_mask_reg != '0);
    assign hit        = (head_item.mask != '0);
    assign time_diff  = (head_item.tag_time != pend_time_reg);
    assign flush_now  = head_item.ovf ? pend_any : (hit && pend_any && time_diff);
    assign emit_any   = head_item.ovf || flush_now;
    assign two_words  = head_item.ovf && pend_any;
    assign out_free   = !out_valid_reg || m_tready;
    assign sel_marker = head_item.ovf && ((phase_reg == PH_SECOND) || !pend_any);
    assign is_last    = !(two_words && (phase_reg == PH_FIRST));
    assign load_out   = head_valid && emit_any && out_free;
    assign head_pop   = head_valid && (!emit_any || (out_free && is_last));

    always_comb begin
        phase_next     = phase_reg;
        pend_time_next = pend_time_reg;
        pend_mask_next = pend_mask_reg;
        if (load_out && !is_last) begin
            phase_next = PH_SECOND;
        end else if (head_pop) begin
            phase_next = PH_FIRST;
        end
        if (head_pop) begin
            if (hit) begin
                if (head_item.ovf || !pend_any || time_diff) begin
                    pend_time_next = head_item.tag_time;
                    pend_mask_next = head_item.mask;
                end else begin
                    pend_mask_next = pend_mask_reg | head_item.mask;
                end
            end else if (head_item.ovf) begin
                pend_time_next = '0;
                pend_mask_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_FIRST;
            pend_time_reg <= '0;
            pend_mask_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            pend_time_reg <= pend_time_next;
            pend_mask_reg <= pend_mask_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_last_reg <= is_last;
            if (sel_marker) begin
                out_time_reg   <= head_item.tag_time[TIME_BITS-1:0];
                out_marker_reg <= MARKER_OVERFLOW;
                out_mask_reg   <= '0;
            end else begin
                out_time_reg   <= pend_time_reg[TIME_BITS-1:0];
                out_marker_reg <= MARKER_NONE;
                out_mask_reg   <= pend_mask_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_mask_reg, out_marker_reg, out_time_reg});
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/time_tag_coincidence_packer_unit.sv */
// Top level of the time tag coincidence packer: configuration registers and block wiring.
//
// Each input transaction is one photon time tag. Its picosecond timestamp is
// divided by 125 and cut to TIME_BITS bits, and its channel is compared with
// the active slots of the channel table; every matching slot sets its bit in
// a pending coincidence mask held for one scaled time. A matching tag at a new
// time first sends the pending word out; an overflow tag sends the pending
// word (if any) and then a marker word with marker code 1 and an empty mask.
// Output words carry tlast on the final word caused by one tag. The block
// accepts one tag per clock while s_tready is high. A tag causes at most
// one output word per cycle, so an overflow tag with a pending word sends
// its two words one after the other. An input transaction reaches its first
// output word through five stages of the reciprocal-multiply divider, the
// four-entry queue and the output register. The queue lets the divider keep
// taking tags while the output side is held off; when the queue is full and
// the last divider stage is holding a tag, s_tready drops.
// Configuration writes (cfg_wr_en, cfg_addr, cfg_wdata) take effect at once
// and are meant to be issued only while no tag is in flight.
module time_tag_coincidence_packer_unit
    import ttcp_pkg::*;
#(
    parameter int NUM_SLOTS       = NUM_SLOTS_DEF,
    parameter int CHANNEL_ID_BITS = CHANNEL_ID_BITS_DEF,
    parameter int TIME_BITS       = TIME_BITS_DEF,
    parameter int OUT_W           = ((TIME_BITS + 1 + MASK_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [TBL_W-1:0]      cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // timestamp [62:0], channel [68:63], zero fill
    input  logic                  s_tuser,   // overflow

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // word_time, word_marker, word_mask, zero fill
    output logic                  m_tlast    // last_of_run
);

    logic [TBL_W-1:0] channel_table_reg;
    logic [CIU_W-1:0] channels_in_use_reg;

    logic       fr_valid, fr_ready;
    ttcp_item_t fr_item;
    logic       q_valid, q_pop;
    ttcp_item_t q_item;

    // Configuration registers. The slot count is written as is; counts above
    // NUM_SLOTS simply enable every implemented slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_table_reg   <= CHANNEL_TABLE_RST;
            channels_in_use_reg <= CHANNELS_IN_USE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_CHANNEL_TABLE:   channel_table_reg   <= cfg_wdata;
                CFG_CHANNELS_IN_USE: channels_in_use_reg <= cfg_wdata[CIU_W-1:0];
                default: ;
            endcase
        end
    end

    // The front matches slots and scales the time; it never looks at the
    // pending word, so it runs ahead of the back.
    ttcp_front #(
        .NUM_SLOTS       (NUM_SLOTS),
        .CHANNEL_ID_BITS (CHANNEL_ID_BITS),
        .TIME_BITS       (TIME_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_ts           (s_tdata[TS_W-1:0]),
        .in_ch           (s_tdata[TS_W +: CH_W]),
        .in_ovf          (s_tuser),
        .channel_table   (channel_table_reg),
        .channels_in_use (channels_in_use_reg),
        .out_valid       (fr_valid),
        .out_ready       (fr_ready),
        .out_item        (fr_item)
    );

    ttcp_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_item  (fr_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_item  (q_item)
    );

    // The back owns the pending word and decides which words go out.
    ttcp_back #(
        .TIME_BITS (TIME_BITS),
        .OUT_W     (OUT_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head_item  (q_item),
        .head_pop   (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

/* bench/tb.sv */
// Self-checking bench for the time tag coincidence packer, with its own word predictor.
module tb;
    import ttcp_pkg::*;

    localparam int OUT_W = ((TIME_BITS_DEF + 1 + MASK_W + 7) / 8) * 8;

    // One photon time tag as it is offered on the input stream.
    typedef struct packed {
        logic            ovf;
        logic [CH_W-1:0] ch;
        logic [TS_W-1:0] ts;
    } tag_t;

    // One packed output word, with the end-of-run flag that travels as tlast.
    typedef struct packed {
        logic                  run_end;
        logic [MASK_W-1:0]     mask;
        logic                  marker;
        logic [TIME_W_MAX-1:0] wtime;
    } word_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [TBL_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tlast;

    time_tag_coincidence_packer_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // timestamp [62:0], channel [68:63], zero fill
        .s_tuser   (s_tuser),    // overflow
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // word_time [48:0], word_marker [49], word_mask [57:50], zero fill
        .m_tlast   (m_tlast)     // last_of_run
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Tags waiting to be offered, and packed words the block still owes us.
    tag_t  tag_queue[$];
    word_t words_due[$];
    word_t fresh_words[$];

    // Our own copy of the configuration and of the pending coincidence word.
    logic [TBL_W-1:0]      cur_table = CHANNEL_TABLE_RST;
    logic [CIU_W-1:0]      cur_slots = CHANNELS_IN_USE_RST;
    logic [TIME_W_MAX-1:0] pend_time = '0;
    logic [MASK_W-1:0]     pend_mask = '0;

    // Handshake bookkeeping shared between the edge processes.
    tag_t        tag_on_bus;
    logic        tag_taken  = 1'b0;
    logic        word_taken = 1'b0;
    bit          tx_idle    = 1'b0;
    bit          rx_idle    = 1'b0;
    int unsigned tx_gap     = 0;
    int unsigned rx_gap     = 0;
    int unsigned rx_hold    = 0;

    int errors        = 0;
    int tags_sent     = 0;
    int ovf_tags      = 0;
    int words_checked = 0;
    int markers_seen  = 0;
    int in_stalls     = 0;
    int cfg_writes    = 0;

    task automatic flag_mismatch(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // Sends out whatever coincidence word is pending and clears it.
    function automatic void close_pending();
        word_t w;
        if (pend_mask != '0) begin
            w = '{run_end: 1'b0, mask: pend_mask, marker: MARKER_NONE, wtime: pend_time};
            fresh_words.insert(fresh_words.size(), w);
            pend_mask = '0;
            pend_time = '0;
        end
    endfunction

    // Works out the words that one accepted tag causes and queues them.
    function automatic void pack_coincidence(input tag_t tg);
        logic [63:0]           quo;
        logic [TIME_W_MAX-1:0] t;
        logic [CH_W-1:0]       id;
        int                    nslots;
        int                    n;
        word_t                 w;
        quo = {1'b0, tg.ts} / 64'd125;
        t = quo[TIME_W_MAX-1:0];
        nslots = (int'(cur_slots) > NUM_SLOTS_DEF) ? NUM_SLOTS_DEF : int'(cur_slots);
        fresh_words.delete();
        if (tg.ovf) begin
            close_pending();
            w = '{run_end: 1'b0, mask: '0, marker: MARKER_OVERFLOW, wtime: t};
            fresh_words.insert(fresh_words.size(), w);
        end
        for (n = 0; n < nslots; n++) begin
            id = cur_table[n*CH_W +: CH_W];
            if (id == tg.ch) begin
                // A matching tag at a new scaled time closes the old word first.
                if (pend_mask != '0 && t != pend_time) close_pending();
                pend_time = t;
                pend_mask[n] = 1'b1;
            end
        end
        if (fresh_words.size() > 0) fresh_words[fresh_words.size()-1].run_end = 1'b1;
        foreach (fresh_words[i]) words_due.insert(words_due.size(), fresh_words[i]);
    endfunction

    // Sender: offers the next tag at the falling edge once the previous
    // transaction has completed and its idle gap has run out.
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !tag_taken)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (tag_queue.size() > 0) begin
                tag_on_bus = tag_queue.pop_front();
                s_tdata  <= {{(IN_W - TS_W - CH_W){1'b0}}, tag_on_bus.ch, tag_on_bus.ts};
                s_tuser  <= tag_on_bus.ovf;
                s_tvalid <= 1'b1;
                tx_gap = tx_idle ? $urandom_range(0, 9) : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: after each word it may stall for a random gap, and a long
    // hold-off requested by the stimulus is counted down here.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (word_taken) rx_gap = rx_idle ? $urandom_range(0, 9) : 0;
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Both channels are sampled at the rising edge. An accepted tag updates
    // the prediction; an accepted word is checked against the oldest one due.
    always @(posedge aclk) begin : monitor
        word_t got;
        word_t want;
        tag_taken  = (s_tvalid && s_tready) === 1'b1;
        word_taken = (m_tvalid && m_tready) === 1'b1;
        if (aresetn) begin
            if (s_tvalid && s_tready !== 1'b1) in_stalls++;
            if (tag_taken) begin
                pack_coincidence(tag_on_bus);
                tags_sent++;
            end
            if (word_taken) begin
                got.wtime   = m_tdata[TIME_W_MAX-1:0];
                got.marker  = m_tdata[TIME_W_MAX];
                got.mask    = m_tdata[TIME_W_MAX+1 +: MASK_W];
                got.run_end = m_tlast;
                words_checked++;
                if (got.marker === MARKER_OVERFLOW) markers_seen++;
                if (words_due.size() == 0) begin
                    flag_mismatch($sformatf("word %h arrived with nothing due", m_tdata));
                end else begin
                    want = words_due.pop_front();
                    if (got.wtime !== want.wtime)
                        flag_mismatch($sformatf("word_time %h, predicted %h",
                                                got.wtime, want.wtime));
                    if (got.marker !== want.marker)
                        flag_mismatch($sformatf("word_marker %b, predicted %b",
                                                got.marker, want.marker));
                    if (got.mask !== want.mask)
                        flag_mismatch($sformatf("word_mask %h, predicted %h",
                                                got.mask, want.mask));
                    if (got.run_end !== want.run_end)
                        flag_mismatch($sformatf("last_of_run %b, predicted %b",
                                                got.run_end, want.run_end));
                end
            end
        end
    end

    task automatic add_tag(input logic [TS_W-1:0] ts, input logic [CH_W-1:0] ch,
                           input logic ovf);
        tag_t tg;
        tg = '{ovf: ovf, ch: ch, ts: ts};
        tag_queue.insert(tag_queue.size(), tg);
        if (ovf) ovf_tags++;
    endtask

    // Register writes happen only with the block idle; the predictor's copy
    // changes together with the register.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [TBL_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        if (idx == CFG_CHANNEL_TABLE) cur_table = value;
        else cur_slots = value[CIU_W-1:0];
        cfg_writes++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Waits until every tag is in and every due word is out, then lets tags
    // that cause no word drain through the divider and the queue.
    task automatic settle();
        while (tag_queue.size() != 0 || s_tvalid || words_due.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // Tags mostly march forward in small steps so that coincidences form,
    // with a few random timestamps and unlisted channels as noise.
    task automatic random_phase(input int count, input int ovf_pct);
        logic [TS_W-1:0] base;
        tag_t            tg;
        int              slot;
        base = TS_W'({$urandom, $urandom});
        repeat (count) begin
            if ($urandom_range(0, 99) < 6) begin
                tg.ts = TS_W'({$urandom, $urandom});
            end else begin
                if ($urandom_range(0, 2) == 0) base = base + TS_W'($urandom_range(1, 400));
                tg.ts = base;
            end
            if ($urandom_range(0, 9) == 0) begin
                tg.ch = CH_W'($urandom_range(0, 63));
            end else begin
                slot = $urandom_range(0, NUM_SLOTS_DEF - 1);
                tg.ch = cur_table[slot*CH_W +: CH_W];
            end
            tg.ovf = ($urandom_range(0, 99) < ovf_pct);
            add_tag(tg.ts, tg.ch, tg.ovf);
        end
    endtask

    localparam logic [TS_W-1:0] TS_MAX    = '1;
    localparam logic [TS_W-1:0] WRAP_STEP = TS_W'(125) << TIME_W_MAX;

    initial begin : stimulus
        logic [TBL_W-1:0] dup_table;
        logic [CH_W-1:0]  id_a;
        logic [CH_W-1:0]  id_b;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part with the reset table, where slot n holds channel n.
        add_tag(TS_W'(0), CH_W'(0), 1'b0);          // opens a word at scaled time 0
        add_tag(TS_W'(124), CH_W'(1), 1'b0);        // same scaled time, second slot
        add_tag(TS_W'(125), CH_W'(2), 1'b0);        // new time closes the first word
        add_tag(TS_MAX, CH_W'(63), 1'b0);           // no slot holds channel 63
        add_tag(TS_MAX, CH_W'(7), 1'b0);            // largest timestamp, top slot
        add_tag(TS_W'(500), CH_W'(3), 1'b1);        // overflow with a word pending
        add_tag(TS_W'(1000), CH_W'(60), 1'b1);      // overflow, no matching slot
        add_tag(TS_W'(1000), CH_W'(60), 1'b1);      // overflow with nothing pending
        add_tag(TS_W'(125 * 5), CH_W'(4), 1'b0);
        add_tag(TS_W'(125 * 5) + WRAP_STEP, CH_W'(5), 1'b0); // wraps onto the same word
        add_tag(TS_W'(125 * 6), CH_W'(6), 1'b1);    // overflow whose tag also matches
        settle();

        // Every slot holds the same id, so one tag sets the whole mask.
        write_reg(CFG_CHANNEL_TABLE, {NUM_SLOTS_DEF{CH_W'(5)}});
        add_tag(TS_W'(250), CH_W'(5), 1'b0);
        add_tag(TS_W'(250), CH_W'(5), 1'b1);
        settle();

        // No active slots: apart from the word left pending before, only overflow markers come out.
        write_reg(CFG_CHANNELS_IN_USE, '0);
        add_tag(TS_W'(375), CH_W'(5), 1'b0);
        add_tag(TS_W'(375), CH_W'(5), 1'b1);
        add_tag(TS_W'(376), CH_W'(0), 1'b1);
        settle();

        // A slot count past the table size behaves as a full table.
        write_reg(CFG_CHANNEL_TABLE, '1);
        write_reg(CFG_CHANNELS_IN_USE, '1);
        add_tag(TS_MAX - 124, CH_W'(63), 1'b0);
        add_tag(TS_MAX - 250, CH_W'(63), 1'b0);
        add_tag(TS_W'(0), CH_W'(62), 1'b1);
        settle();

        // Only the first three slots active.
        write_reg(CFG_CHANNEL_TABLE, CHANNEL_TABLE_RST);
        write_reg(CFG_CHANNELS_IN_USE, TBL_W'(3));
        add_tag(TS_W'(0), CH_W'(3), 1'b0);
        add_tag(TS_W'(0), CH_W'(2), 1'b0);
        add_tag(TS_W'(125), CH_W'(7), 1'b1);
        add_tag(TS_W'(125), CH_W'(0), 1'b0);
        settle();

        // Random phases. Each one ends with the sender paused until every
        // word has arrived, so the register writes find the block idle.
        write_reg(CFG_CHANNELS_IN_USE, TBL_W'(NUM_SLOTS_DEF));
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        random_phase(300, 4);
        settle();

        write_reg(CFG_CHANNEL_TABLE, TBL_W'({$urandom, $urandom}));
        write_reg(CFG_CHANNELS_IN_USE, TBL_W'($urandom_range(1, NUM_SLOTS_DEF)));
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        random_phase(300, 5);
        settle();

        // Only two distinct ids spread over the table.
        id_a = CH_W'($urandom);
        id_b = CH_W'($urandom);
        for (int n = 0; n < NUM_SLOTS_DEF; n++)
            dup_table[n*CH_W +: CH_W] = $urandom_range(0, 1) ? id_a : id_b;
        write_reg(CFG_CHANNEL_TABLE, dup_table);
        write_reg(CFG_CHANNELS_IN_USE, TBL_W'(NUM_SLOTS_DEF));
        tx_idle = 1'b1;
        rx_idle = 1'b0;
        random_phase(250, 5);
        settle();

        // The receiver holds off for a long stretch while the sender keeps
        // offering back to back, so the block fills and drops s_tready.
        write_reg(CFG_CHANNEL_TABLE, TBL_W'({$urandom, $urandom}));
        write_reg(CFG_CHANNELS_IN_USE, TBL_W'($urandom_range(NUM_SLOTS_DEF + 1, 15)));
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        rx_hold = 400;
        random_phase(300, 6);
        settle();

        // Empty table with no active slots; overflow tags are frequent here.
        write_reg(CFG_CHANNEL_TABLE, '0);
        write_reg(CFG_CHANNELS_IN_USE, '0);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        random_phase(150, 30);
        settle();

        write_reg(CFG_CHANNEL_TABLE, TBL_W'({$urandom, $urandom}));
        write_reg(CFG_CHANNELS_IN_USE, TBL_W'($urandom_range(0, 15)));
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        random_phase(250, 5);
        settle();

        $display("tb: %0d tags (%0d overflow), %0d words checked, %0d of them markers",
                 tags_sent, ovf_tags, words_checked, markers_seen);
        $display("tb: %0d register writes, %0d cycles with the input stalled, %0d mismatches",
                 cfg_writes, in_stalls, errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
